/* src/pic_pkg.sv */
`timescale 1ns / 1ps

package pic_pkg;

  localparam int NUM_LINES = 8;
  localparam int LEVEL_W   = $clog2(NUM_LINES);

  // Request codes.
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_LINES = 2'd2;
  localparam logic [1:0] CMD_ACK   = 2'd3;

  // Bit positions of the A0=0 write byte.
  localparam int ICW1_BIT    = 4;
  localparam int OCW3_BIT    = 3;
  localparam int OCW3_RR_BIT = 1;
  localparam int OCW3_RIS_BIT = 0;
  localparam int ICW4_BIT    = 0;

  // OCW2 command codes in bits 7..5.
  localparam logic [2:0] OCW2_EOI_NONSPEC = 3'd1;
  localparam logic [2:0] OCW2_EOI_SPEC    = 3'd3;

  localparam logic [7:0] MASK_RESET  = 8'hFF;
  localparam logic [7:0] VECTOR_MASK = 8'hF8;

  // Initialization steps.
  localparam logic [1:0] STEP_ICW1 = 2'd0;
  localparam logic [1:0] STEP_ICW2 = 2'd1;
  localparam logic [1:0] STEP_DONE_NO_ICW4 = 2'd2;
  localparam logic [1:0] STEP_DONE_ICW4    = 2'd3;

  typedef struct packed {
    logic               found;
    logic [LEVEL_W-1:0] level;
  } prio_t;

endpackage

/* src/pic_if.sv */
`timescale 1ns / 1ps

interface pic_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic       addr_bit;
  logic [7:0] write_data;
  logic [7:0] ir_lines;

  modport source (output valid, command, addr_bit, write_data, ir_lines, input ready);
  modport sink   (input valid, command, addr_bit, write_data, ir_lines, output ready);
endinterface

interface pic_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       int_request;
  logic       vector_valid;
  logic [7:0] vector_byte;

  modport source (output valid, read_data, int_request, vector_valid, vector_byte,
                  input ready);
  modport sink   (input valid, read_data, int_request, vector_valid, vector_byte,
                  output ready);
endinterface

/* src/programmable_interrupt_controller_core.sv */
`timescale 1ns / 1ps
// Channel  | Modport      | Moves
// in_ch    | sink         | bus write, bus read, request line level, acknowledge
// out_ch   | source       | read data, interrupt level, vector valid, vector byte
//
// A request is taken at the edge where in_ch.valid and in_ch.ready are both high, and its
// result is loaded into the output register at that same edge, so it is offered in the next
// cycle; a new request may be accepted every cycle while the output is not stalled.
// The result is set by one priority encoder pass in front of the output register.
// Reset (rst_n low, synchronous) clears all controller state; the mask is all ones.
// A stalled output holds its result and stops new requests until it is taken.

module programmable_interrupt_controller_core (
  input  logic             clk,
  input  logic             rst_n,
  pic_in_if.sink           in_ch,
  pic_out_if.source        out_ch
);

  logic [7:0] request_r, request_nxt;
  logic [7:0] in_service_r, in_service_nxt;
  logic [7:0] mask_r, mask_nxt;
  logic       icw4_r, icw4_nxt;
  logic [7:0] vector_base_r, vector_base_nxt;
  logic [1:0] init_step_r, init_step_nxt;
  logic       init_done_r, init_done_nxt;
  logic       status_sel_r, status_sel_nxt;
  logic [7:0] prev_lines_r, prev_lines_nxt;
  logic       int_level_r, int_level_nxt;

  logic       out_valid_r;
  logic [7:0] read_data_r, read_data_nxt;
  logic       vector_valid_r, vector_valid_nxt;
  logic [7:0] vector_byte_r, vector_byte_nxt;

  logic       accept;
  logic       evaluate;
  logic [7:0] wdata;

  pic_pkg::prio_t ack_best, req_best, svc_best;

  pic_prio u_ack_prio (.bits(request_r & ~mask_r), .best(ack_best));
  pic_prio u_req_prio (.bits(request_nxt & ~mask_nxt), .best(req_best));
  pic_prio u_svc_prio (.bits(in_service_nxt), .best(svc_best));

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign wdata       = in_ch.write_data;

  always_comb begin
    request_nxt      = request_r;
    in_service_nxt   = in_service_r;
    mask_nxt         = mask_r;
    icw4_nxt         = icw4_r;
    vector_base_nxt  = vector_base_r;
    init_step_nxt    = init_step_r;
    init_done_nxt    = init_done_r;
    status_sel_nxt   = status_sel_r;
    prev_lines_nxt   = prev_lines_r;
    evaluate         = 1'b0;
    read_data_nxt    = '0;
    vector_valid_nxt = 1'b0;
    vector_byte_nxt  = '0;
    int_level_nxt    = int_level_r;

    case (in_ch.command)
      pic_pkg::CMD_WRITE: begin
        if (!in_ch.addr_bit) begin
          if (wdata[pic_pkg::ICW1_BIT]) begin
            icw4_nxt       = wdata[pic_pkg::ICW4_BIT];
            init_step_nxt  = pic_pkg::STEP_ICW2;
            init_done_nxt  = 1'b0;
            mask_nxt       = '0;
            in_service_nxt = '0;
            request_nxt    = '0;
            status_sel_nxt = 1'b0;
            int_level_nxt  = 1'b0;
          end else if (wdata[pic_pkg::OCW3_BIT]) begin
            if (wdata[pic_pkg::OCW3_RR_BIT]) begin
              status_sel_nxt = wdata[pic_pkg::OCW3_RIS_BIT];
            end
          end else begin
            case (wdata[7:5])
              pic_pkg::OCW2_EOI_NONSPEC: begin
                in_service_nxt = in_service_r & (in_service_r - 8'd1);
              end
              pic_pkg::OCW2_EOI_SPEC: begin
                in_service_nxt = in_service_r & ~(8'd1 << wdata[2:0]);
              end
              default: begin
                in_service_nxt = in_service_r;
              end
            endcase
            evaluate = 1'b1;
          end
        end else if (!init_done_r) begin
          if (init_step_r == pic_pkg::STEP_ICW1) begin
            icw4_nxt = wdata[pic_pkg::ICW4_BIT];
          end else if (init_step_r == pic_pkg::STEP_ICW2) begin
            vector_base_nxt = wdata;
          end
          init_step_nxt = init_step_r + 2'd1;
          if ((init_step_nxt == pic_pkg::STEP_DONE_NO_ICW4 && !icw4_nxt) ||
              (init_step_nxt == pic_pkg::STEP_DONE_ICW4 && icw4_nxt)) begin
            init_done_nxt = 1'b1;
          end
        end else begin
          mask_nxt = wdata;
          evaluate = 1'b1;
        end
      end
      pic_pkg::CMD_READ: begin
        if (in_ch.addr_bit) begin
          read_data_nxt = mask_r;
        end else begin
          read_data_nxt = status_sel_r ? in_service_r : request_r;
        end
      end
      pic_pkg::CMD_LINES: begin
        request_nxt    = request_r | (in_ch.ir_lines & ~prev_lines_r);
        prev_lines_nxt = in_ch.ir_lines;
        evaluate       = 1'b1;
      end
      pic_pkg::CMD_ACK: begin
        if (ack_best.found) begin
          in_service_nxt   = in_service_r | (8'd1 << ack_best.level);
          request_nxt      = request_r & ~(8'd1 << ack_best.level);
          vector_valid_nxt = 1'b1;
          vector_byte_nxt  = (vector_base_r & pic_pkg::VECTOR_MASK) | 8'(ack_best.level);
        end
        int_level_nxt = 1'b0;
      end
      default: begin
        evaluate = 1'b0;
      end
    endcase

    if (evaluate) begin
      int_level_nxt = req_best.found &&
                      (!svc_best.found || (req_best.level < svc_best.level));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      request_r     <= '0;
      in_service_r  <= '0;
      mask_r        <= pic_pkg::MASK_RESET;
      icw4_r        <= 1'b0;
      vector_base_r <= '0;
      init_step_r   <= pic_pkg::STEP_ICW1;
      init_done_r   <= 1'b0;
      status_sel_r  <= 1'b0;
      prev_lines_r  <= '0;
      int_level_r   <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (accept) begin
        request_r     <= request_nxt;
        in_service_r  <= in_service_nxt;
        mask_r        <= mask_nxt;
        icw4_r        <= icw4_nxt;
        vector_base_r <= vector_base_nxt;
        init_step_r   <= init_step_nxt;
        init_done_r   <= init_done_nxt;
        status_sel_r  <= status_sel_nxt;
        prev_lines_r  <= prev_lines_nxt;
        int_level_r   <= int_level_nxt;
        out_valid_r   <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      read_data_r    <= read_data_nxt;
      vector_valid_r <= vector_valid_nxt;
      vector_byte_r  <= vector_byte_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.read_data    = read_data_r;
  assign out_ch.int_request  = int_level_r;
  assign out_ch.vector_valid = vector_valid_r;
  assign out_ch.vector_byte  = vector_byte_r;

endmodule

/* src/pic_prio.sv */
`timescale 1ns / 1ps

module pic_prio (
  input  logic [pic_pkg::NUM_LINES-1:0] bits,
  output pic_pkg::prio_t                best
);

  always_comb begin
    best = '0;
    for (int i = pic_pkg::NUM_LINES - 1; i >= 0; i--) begin
      if (bits[i]) begin
        best.found = 1'b1;
        best.level = pic_pkg::LEVEL_W'(i);
      end
    end
  end

endmodule

/* src/pic_checker.sv */
`timescale 1ns / 1ps

module pic_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_read_data,
  input logic       out_int_request,
  input logic       out_vector_valid,
  input logic [7:0] out_vector_byte
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_data) &&
    $stable(out_vector_byte) && $stable(out_vector_valid))
    else $error("stalled result changed");

  // An accepted request always shows a result on the next edge.
  a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted request gave no result");

  // A granted vector drops the interrupt output and comes with zero read data.
  a_ack_drops_int: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_vector_valid |-> !out_int_request && out_read_data == 8'd0)
    else $error("vector granted with interrupt still high");

  // Without a grant the vector byte is zero.
  a_no_vector_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_vector_valid |-> out_vector_byte == 8'd0)
    else $error("vector byte set without grant");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind programmable_interrupt_controller_core pic_checker u_pic_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_read_data    (out_ch.read_data),
  .out_int_request  (out_ch.int_request),
  .out_vector_valid (out_ch.vector_valid),
  .out_vector_byte  (out_ch.vector_byte)
);
